>>> sv/lslf_pkg.sv
package lslf_pkg;

	localparam int unsigned DEF_MAX_POINTS = 4096;
	localparam int unsigned DEF_COORD_BITS = 10;

	// Width of the fit datapath
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned FRAC_BITS = 16;

	localparam int unsigned CFG_W     = 11;
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0]     DIM_RESET        = 11'd500;

	localparam int unsigned OUT_DATA_W = 224;
	localparam int unsigned OUT_USER_W = 2;

	localparam logic signed [WORD_W-1:0] Q_ONE   = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [WORD_W-1:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [WORD_W-1:0] S48_MIN = 64'shFFFF_8000_0000_0000;
	localparam logic signed [WORD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef logic signed [WORD_W-1:0] word_t;

	// Snapshot of the accumulators for one point set
	typedef struct packed {
		logic [WORD_W-1:0] n;
		logic [WORD_W-1:0] sx;
		logic [WORD_W-1:0] sy;
		logic [WORD_W-1:0] sxx;
		logic [WORD_W-1:0] sxy;
	} sums_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} op_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] res;
	} op_rsp_t;

	function automatic word_t clamp48(input word_t v);
		if (v > S48_MAX) return S48_MAX;
		if (v < S48_MIN) return S48_MIN;
		return v;
	endfunction

	function automatic logic [31:0] sat32(input word_t v);
		if (v > S32_MAX) return 32'h7FFF_FFFF;
		if (v < S32_MIN) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Divide by 2^FRAC_BITS, truncating toward zero
	function automatic word_t trunc_q(input word_t v);
		word_t b;
		b = v + (v[WORD_W-1] ? (Q_ONE - 64'sd1) : 64'sd0);
		return b >>> FRAC_BITS;
	endfunction

endpackage

>>> sv/lslf_acc.sv
module lslf_acc #(
	parameter int unsigned MAX_POINTS = lslf_pkg::DEF_MAX_POINTS,
	parameter int unsigned COORD_BITS = lslf_pkg::DEF_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pt_valid,
	output logic                  pt_ready,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic                  pt_last,
	input  logic                  job_room,
	output logic                  job_valid,
	output lslf_pkg::sums_t       job
);
	import lslf_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
	localparam int unsigned SUM_W = COORD_BITS + CNT_W;
	localparam int unsigned SQ_W  = 2 * COORD_BITS + CNT_W;

	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [SUM_W-1:0] sx_q, sy_q, sx_nxt, sy_nxt;
	logic [SQ_W-1:0]  sxx_q, sxy_q, sxx_nxt, sxy_nxt;
	logic [2*COORD_BITS-1:0] pxx, pxy;
	logic accept, keep;

	assign pt_ready = job_room;
	assign accept   = pt_valid && pt_ready;
	assign keep     = cnt_q < CNT_W'(MAX_POINTS);
	assign pxx      = px * px;
	assign pxy      = px * py;

	// Drop points beyond the limit; the count saturates
	always_comb begin
		cnt_nxt = cnt_q;
		sx_nxt  = sx_q;
		sy_nxt  = sy_q;
		sxx_nxt = sxx_q;
		sxy_nxt = sxy_q;
		if (keep) begin
			cnt_nxt = cnt_q + CNT_W'(1);
			sx_nxt  = sx_q + SUM_W'(px);
			sy_nxt  = sy_q + SUM_W'(py);
			sxx_nxt = sxx_q + SQ_W'(pxx);
			sxy_nxt = sxy_q + SQ_W'(pxy);
		end
	end

	assign job_valid = accept && pt_last;
	assign job.n     = WORD_W'(cnt_nxt);
	assign job.sx    = WORD_W'(sx_nxt);
	assign job.sy    = WORD_W'(sy_nxt);
	assign job.sxx   = WORD_W'(sxx_nxt);
	assign job.sxy   = WORD_W'(sxy_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (accept) begin
			if (pt_last) begin
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				sxy_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
				sx_q  <= sx_nxt;
				sy_q  <= sy_nxt;
				sxx_q <= sxx_nxt;
				sxy_q <= sxy_nxt;
			end
		end
	end

endmodule

>>> sv/lslf_mul.sv
module lslf_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  lslf_pkg::op_req_t req,
	output lslf_pkg::op_rsp_t rsp
);
	import lslf_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] a_q, b_q, p_q;

	assign rsp.done = done_q;
	assign rsp.res  = p_q;

	// Shift-add, one multiplier bit per cycle; low word of the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (&cnt_q);
			if (req.start) begin
				a_q    <= req.a;
				b_q    <= req.b;
				p_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) p_q <= p_q + a_q;
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
				if (&cnt_q) busy_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/lslf_div.sv
module lslf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lslf_pkg::op_req_t req,
	output lslf_pkg::op_rsp_t rsp
);
	import lslf_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic              busy_q, done_q, neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic [WORD_W:0]   rem_sh, diff;

	assign rem_sh   = {rem_q, quo_q[WORD_W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign rsp.done = done_q;
	assign rsp.res  = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

	// Signed quotient truncated toward zero: restoring division on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (&cnt_q);
			if (req.start) begin
				neg_q  <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
				quo_q  <= req.a[WORD_W-1] ? (~req.a + WORD_W'(1)) : req.a;
				dvs_q  <= req.b[WORD_W-1] ? (~req.b + WORD_W'(1)) : req.b;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!diff[WORD_W]) begin
					rem_q <= diff[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
				if (&cnt_q) busy_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/lslf_solve.sv
module lslf_solve (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  lslf_pkg::sums_t                    job,
	input  logic [lslf_pkg::CFG_W-1:0]         img_w,
	input  logic [lslf_pkg::CFG_W-1:0]         img_h,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lslf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [lslf_pkg::OUT_USER_W-1:0]    m_tuser
);
	import lslf_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_MUL1 = 14'b00000000000010,
		ST_MUL2 = 14'b00000000000100,
		ST_CHK  = 14'b00000000001000,
		ST_MUL3 = 14'b00000000010000,
		ST_MUL4 = 14'b00000000100000,
		ST_DIV1 = 14'b00000001000000,
		ST_MUL5 = 14'b00000010000000,
		ST_DIV2 = 14'b00000100000000,
		ST_MUL6 = 14'b00001000000000,
		ST_DIV3 = 14'b00010000000000,
		ST_DIV4 = 14'b00100000000000,
		ST_EMIT = 14'b01000000000000,
		ST_HOLD = 14'b10000000000000
	} state_t;

	state_t  state_q;
	op_req_t mreq, dreq;
	op_rsp_t mrsp, drsp;
	logic    mstart_q, dstart_q, m_go, d_go;
	logic [WORD_W-1:0] ma_q, mb_q, da_q, db_q;
	word_t   n_q, sx_q, sy_q, sxy_q, t_q, den_q;
	word_t   slope_q, icpt_q, x1_q, y1_q, x2_q, y2_q;
	logic    steep_q, degen_q;
	word_t   mres, dres, slope_c, icpt_c, w_m1, h_m1;
	logic    steep_c, degen_c;
	logic    out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	assign mreq = '{start: mstart_q, a: ma_q, b: mb_q};
	assign dreq = '{start: dstart_q, a: da_q, b: db_q};

	lslf_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	lslf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign mres    = word_t'(mrsp.res);
	assign dres    = word_t'(drsp.res);
	assign slope_c = clamp48(dres);
	assign icpt_c  = clamp48(dres);
	assign steep_c = !((slope_q > -Q_ONE) && (slope_q < Q_ONE));
	assign degen_c = (n_q == '0) || (den_q == '0);
	assign w_m1    = word_t'({{(WORD_W-CFG_W){1'b0}}, img_w}) - 64'sd1;
	assign h_m1    = word_t'({{(WORD_W-CFG_W){1'b0}}, img_h}) - 64'sd1;

	assign job_ready = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	// Launch the next serial operation as the current step finishes
	always_comb begin
		m_go = 1'b0;
		d_go = 1'b0;
		unique case (state_q)
			ST_IDLE:          m_go = job_valid;
			ST_MUL1, ST_MUL3: m_go = mrsp.done;
			ST_CHK:           m_go = !degen_c;
			ST_MUL4, ST_MUL5: d_go = mrsp.done;
			ST_DIV1:          m_go = drsp.done;
			ST_DIV2: begin
				m_go = drsp.done && !steep_c;
				d_go = drsp.done && steep_c;
			end
			ST_DIV3:          d_go = drsp.done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mstart_q    <= 1'b0;
			dstart_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mstart_q <= m_go;
			dstart_q <= d_go;
			if (out_valid_q && m_tready && state_q != ST_HOLD) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						n_q   <= word_t'(job.n);
						sx_q  <= word_t'(job.sx);
						sy_q  <= word_t'(job.sy);
						sxy_q <= word_t'(job.sxy);
						ma_q  <= job.n;
						mb_q  <= job.sxx;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (mrsp.done) begin
						t_q     <= mres;
						ma_q    <= sx_q;
						mb_q    <= sx_q;
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (mrsp.done) begin
						den_q   <= t_q - mres;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (degen_c) begin
						slope_q <= '0;
						icpt_q  <= '0;
						x1_q    <= '0;
						y1_q    <= '0;
						x2_q    <= '0;
						y2_q    <= '0;
						steep_q <= 1'b0;
						degen_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						degen_q <= 1'b0;
						ma_q    <= n_q;
						mb_q    <= sxy_q;
						state_q <= ST_MUL3;
					end
				end
				ST_MUL3: begin
					if (mrsp.done) begin
						t_q     <= mres;
						ma_q    <= sx_q;
						mb_q    <= sy_q;
						state_q <= ST_MUL4;
					end
				end
				ST_MUL4: begin
					if (mrsp.done) begin
						da_q    <= (t_q - mres) <<< FRAC_BITS;
						db_q    <= den_q;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (drsp.done) begin
						slope_q <= slope_c;
						ma_q    <= slope_c;
						mb_q    <= sx_q;
						state_q <= ST_MUL5;
					end
				end
				ST_MUL5: begin
					if (mrsp.done) begin
						da_q    <= (sy_q <<< FRAC_BITS) - mres;
						db_q    <= n_q;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (drsp.done) begin
						icpt_q  <= icpt_c;
						steep_q <= steep_c;
						if (!steep_c) begin
							x1_q    <= '0;
							y1_q    <= trunc_q(icpt_c);
							x2_q    <= w_m1;
							ma_q    <= slope_q;
							mb_q    <= w_m1;
							state_q <= ST_MUL6;
						end else begin
							y1_q    <= '0;
							y2_q    <= h_m1;
							da_q    <= -icpt_c;
							db_q    <= slope_q;
							state_q <= ST_DIV3;
						end
					end
				end
				ST_MUL6: begin
					if (mrsp.done) begin
						y2_q    <= trunc_q(icpt_q + mres);
						state_q <= ST_EMIT;
					end
				end
				ST_DIV3: begin
					if (drsp.done) begin
						x1_q    <= dres;
						da_q    <= (y2_q <<< FRAC_BITS) - icpt_q;
						db_q    <= slope_q;
						state_q <= ST_DIV4;
					end
				end
				ST_DIV4: begin
					if (drsp.done) begin
						x2_q    <= dres;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					// Wait for the output register to free up
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {sat32(y2_q), sat32(x2_q), sat32(y1_q), sat32(x1_q),
							icpt_q[47:0], slope_q[47:0]};
						out_user_q  <= {degen_q, steep_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/least_squares_line_fit_unit.sv
// Least-squares line fit. Points stream in on the s_ side, one word per point, and are
// summed (count, x, y, x*x, x*y) at one word per cycle. The word with s_tlast set closes
// a point set: its sums go into a two-entry job queue and the accumulators clear. The
// back end solves each job with one shared serial 64-bit multiplier and one shared
// serial divider. Points keep flowing while the back end works; the input stalls only
// when the job queue holds two sets. Results are Q32.16 slope and intercept, endpoints
// at the image edges saturated to 32 bits, and the steep and degenerate flags.
module least_squares_line_fit_unit #(
	parameter int unsigned MAX_POINTS = lslf_pkg::DEF_MAX_POINTS,
	parameter int unsigned COORD_BITS = lslf_pkg::DEF_COORD_BITS,
	parameter int unsigned IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_we,
	input  logic [lslf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lslf_pkg::CFG_W-1:0]            cfg_data,
	// Point stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [IN_DATA_W-1:0]                  s_tdata,   // point_x, point_y
	input  logic                                  s_tlast,   // last_point
	// Result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lslf_pkg::OUT_DATA_W-1:0]       m_tdata,   // slope, intercept, start_x,
	                                                         // start_y, end_x, end_y
	output logic [lslf_pkg::OUT_USER_W-1:0]       m_tuser    // steep, degenerate
);
	import lslf_pkg::*;

	logic [CFG_W-1:0] img_w_q, img_h_q;

	// Job queue between front and back
	sums_t      fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] fill_q;
	logic       push, pop, room, acc_job_valid, solve_ready;
	sums_t      acc_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= DIM_RESET;
			img_h_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lslf_acc #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (s_tvalid),
		.pt_ready (s_tready),
		.px       (s_tdata[COORD_BITS-1:0]),
		.py       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.pt_last  (s_tlast),
		.job_room (room),
		.job_valid(acc_job_valid),
		.job      (acc_job)
	);

	// Hold the input while the queue is full
	assign room = (fill_q != 2'd2);
	assign push = acc_job_valid;
	assign pop  = solve_ready && (fill_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				fifo_q[wp_q] <= acc_job;
				wp_q         <= ~wp_q;
			end
			if (pop) rp_q <= ~rp_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	lslf_solve u_solve (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(fill_q != 2'd0),
		.job_ready(solve_ready),
		.job      (fifo_q[rp_q]),
		.img_w    (img_w_q),
		.img_h    (img_h_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
